// ===== hw/rtl/cal_pkg.sv =====
// Shared types, operation codes and constants for the cursor array list.
package cal_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int WORD_W       = 32;
  localparam int FIELD_W      = 7;

  localparam logic [FIELD_W-1:0] LIMIT_RST = 7'd64;

  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_END    = 3'd1;
  localparam logic [2:0] MODE_PREV   = 3'd2;
  localparam logic [2:0] MODE_NEXT   = 3'd3;
  localparam logic [2:0] MODE_INSERT = 3'd4;
  localparam logic [2:0] MODE_APPEND = 3'd5;
  localparam logic [2:0] MODE_REMOVE = 3'd6;
  localparam logic [2:0] MODE_CLEAR  = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_ENTRY = 2'd2;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [WORD_W-1:0] value;
  } cal_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [FIELD_W-1:0]       cursor;
    logic [FIELD_W-1:0]       length;
    logic signed [WORD_W-1:0] cursor_value;
    logic                     cursor_valid;
  } cal_out_t;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [WORD_W-1:0] word;
  } cal_op_t;

endpackage

// ===== hw/rtl/cal_cell.sv =====
// One storage cell of the list: holds a word, takes from a neighbor on a shift.
module cal_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                       clk,
  input  cal_pkg::cal_op_t           op,
  input  logic [CNT_W-1:0]           cursor,
  input  logic [cal_pkg::WORD_W-1:0] left_data,
  input  logic [cal_pkg::WORD_W-1:0] right_data,
  output logic [cal_pkg::WORD_W-1:0] data
);

  logic [cal_pkg::WORD_W-1:0] data_r;
  logic [cal_pkg::WORD_W-1:0] data_nxt;
  logic                       at_cur;
  logic                       past_cur;

  assign at_cur   = (CNT_W'(IDX) == cursor);
  assign past_cur = (CNT_W'(IDX) >  cursor);

  always_comb begin
    data_nxt = data_r;
    if (op.ins) begin
      if (at_cur) begin
        data_nxt = op.word;
      end else if (past_cur) begin
        data_nxt = left_data;
      end
    end else if (op.rem) begin
      if (at_cur || past_cur) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== hw/rtl/cal_chain.sv =====
// Row of list cells with neighbor links and the read port at the cursor.
module cal_chain #(
  parameter int CAPACITY = cal_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  cal_pkg::cal_op_t           op,
  input  logic [CNT_W-1:0]           op_cursor,
  input  logic [CNT_W-1:0]           rd_idx,
  output logic [cal_pkg::WORD_W-1:0] rd_data
);

  logic [cal_pkg::WORD_W-1:0] cell_data [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [cal_pkg::WORD_W-1:0] left_w;
    logic [cal_pkg::WORD_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = op.word;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    cal_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .cursor     (op_cursor),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[i])
    );
  end

  // AND-OR select of the cell under the cursor
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_idx == CNT_W'(i)) begin
        rd_data = rd_data | cell_data[i];
      end
    end
  end

endmodule

// ===== hw/rtl/cursor_array_list_top.sv =====
// Top level of the cursor array list: control, counters and result register.
//
// Ordered list of signed 32-bit words with a cursor, stored in a row of
// CAPACITY cells that shift all at once on insert and remove.
// Input channel in_valid/in_ready/in_data carries one request: a mode
// (start, end, prev, next, insert, append, remove, clear) and a word.
// Result channel out_valid/out_ready/out_data returns one result per
// request: status, cursor, length, the word at the cursor and its valid bit.
// cfg_we/cfg_wdata write the capacity limit; the smaller of it and CAPACITY
// is in force. Write it only while no request is in flight.
// An accepted request updates the counter, cursor and cell registers; the
// word at the new cursor is then read from the cell row into the result
// register. No new request is taken until the previous one is loaded there.
// A new request is taken while the previous result still waits; if the
// receiver stalls, the following result holds in the update stage and the
// input stalls behind it.
// Reset (rst_n low, synchronous) empties the list, sets the cursor to 0 and
// the limit to 64; stored words are not cleared and are never seen again.
module cursor_array_list_top #(
  parameter int CAPACITY = cal_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cal_pkg::cal_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cal_pkg::cal_out_t           out_data,
  input  logic                        cfg_we,
  input  logic [cal_pkg::FIELD_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LW    = (CNT_W > cal_pkg::FIELD_W) ? CNT_W : cal_pkg::FIELD_W;

  logic [cal_pkg::FIELD_W-1:0] limit_r;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [CNT_W-1:0]            cursor_r, cursor_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic                        calc_r;
  logic                        out_valid_r;
  cal_pkg::cal_out_t           out_r;

  cal_pkg::cal_op_t            op;
  logic [CNT_W-1:0]            op_cursor;
  logic [cal_pkg::WORD_W-1:0]  rd_data;
  logic                        accept;
  logic                        full;
  logic                        load_out;
  logic                        cur_valid;

  assign in_ready = !calc_r;
  assign accept   = in_valid && in_ready;
  assign load_out = calc_r && (!out_valid_r || out_ready);

  assign full = (LW'(count_r) >= LW'(limit_r)) || (count_r >= CNT_W'(CAPACITY));

  always_comb begin
    cursor_nxt = cursor_r;
    count_nxt  = count_r;
    status_nxt = cal_pkg::ST_OK;
    op_cursor  = cursor_r;
    op.ins     = 1'b0;
    op.rem     = 1'b0;
    op.word    = in_data.value;
    unique case (in_data.mode)
      cal_pkg::MODE_START: begin
        cursor_nxt = '0;
      end
      cal_pkg::MODE_END: begin
        cursor_nxt = count_r;
      end
      cal_pkg::MODE_PREV: begin
        if (cursor_r != '0) begin
          cursor_nxt = cursor_r - CNT_W'(1);
        end
      end
      cal_pkg::MODE_NEXT: begin
        if (cursor_r < count_r) begin
          cursor_nxt = cursor_r + CNT_W'(1);
        end
      end
      cal_pkg::MODE_INSERT, cal_pkg::MODE_APPEND: begin
        if (in_data.mode == cal_pkg::MODE_APPEND) begin
          cursor_nxt = count_r;
          op_cursor  = count_r;
        end
        if (full) begin
          status_nxt = cal_pkg::ST_FULL;
        end else begin
          op.ins    = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      cal_pkg::MODE_REMOVE: begin
        if (cursor_r >= count_r) begin
          status_nxt = cal_pkg::ST_NO_ENTRY;
        end else begin
          op.rem    = accept;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      cal_pkg::MODE_CLEAR: begin
        cursor_nxt = '0;
        count_nxt  = '0;
      end
    endcase
  end

  cal_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk       (clk),
    .op        (op),
    .op_cursor (op_cursor),
    .rd_idx    (cursor_r),
    .rd_data   (rd_data)
  );

  assign cur_valid = (cursor_r < count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= cal_pkg::LIMIT_RST;
      count_r     <= '0;
      cursor_r    <= '0;
      calc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (accept) begin
        count_r  <= count_nxt;
        cursor_r <= cursor_nxt;
        calc_r   <= 1'b1;
      end else if (load_out) begin
        calc_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
    if (load_out) begin
      out_r.status       <= status_r;
      out_r.cursor       <= cal_pkg::FIELD_W'(cursor_r);
      out_r.length       <= cal_pkg::FIELD_W'(count_r);
      out_r.cursor_value <= cur_valid ? rd_data : '0;
      out_r.cursor_valid <= cur_valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== verif/cursor_array_list_top_tb.sv =====
// Self-checking testbench for the cursor array list top level.
module cursor_array_list_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cal_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_MAX  = 10;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_t;

  // Tracks the list contents and queues the result each request should produce.
  class list_scoreboard;
    logic signed [WORD_W-1:0] words [CAPACITY_DEF];
    int                       count;
    int                       cur;
    logic [FIELD_W-1:0]       limit;
    cal_out_t                 expected_views [$];
    int                       mismatches;
    int                       checked;
    int                       noted;
    int                       deepest;
    int                       full_hits;
    int                       empty_removes;

    function new();
      count = 0;
      cur = 0;
      limit = LIMIT_RST;
      mismatches = 0;
      checked = 0;
      noted = 0;
      deepest = 0;
      full_hits = 0;
      empty_removes = 0;
    endfunction

    function logic [1:0] place_word(logic signed [WORD_W-1:0] w);
      int room;
      room = (limit < CAPACITY_DEF) ? int'(limit) : CAPACITY_DEF;
      if (count >= room) begin
        full_hits++;
        return ST_FULL;
      end
      for (int i = count; i > cur; i--) words[i] = words[i-1];
      words[cur] = w;
      count++;
      return ST_OK;
    endfunction

    function void note_request(cal_in_t req);
      logic [1:0] st;
      cal_out_t   want;
      st = ST_OK;
      case (req.mode)
        MODE_START:  cur = 0;
        MODE_END:    cur = count;
        MODE_PREV:   if (cur != 0) cur--;
        MODE_NEXT:   if (cur < count) cur++;
        MODE_INSERT: st = place_word(req.value);
        MODE_APPEND: begin
          cur = count;
          st = place_word(req.value);
        end
        MODE_REMOVE: begin
          if (cur >= count) begin
            st = ST_NO_ENTRY;
            empty_removes++;
          end else begin
            for (int i = cur; i + 1 < count; i++) words[i] = words[i+1];
            count--;
          end
        end
        MODE_CLEAR: begin
          count = 0;
          cur = 0;
        end
        default: ;
      endcase
      if (count > deepest) deepest = count;
      want.status       = st;
      want.cursor       = FIELD_W'(cur);
      want.length       = FIELD_W'(count);
      want.cursor_valid = (cur < count);
      want.cursor_value = (cur < count) ? words[cur] : '0;
      expected_views.push_back(want);
      noted++;
    endfunction

    function void check_result(cal_out_t got);
      cal_out_t want;
      bit       bad;
      checked++;
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with nothing pending: st=%0d cur=%0d len=%0d word=%0d v=%0b",
                   $time, got.status, got.cursor, got.length, got.cursor_value,
                   got.cursor_valid);
        return;
      end
      want = expected_views.pop_front();
      bad = (got.status !== want.status) || (got.cursor !== want.cursor) ||
            (got.length !== want.length) || (got.cursor_value !== want.cursor_value) ||
            (got.cursor_valid !== want.cursor_valid);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: result %0d mismatch", $time, checked);
          $display("  want st=%0d cur=%0d len=%0d word=%0d v=%0b", want.status,
                   want.cursor, want.length, want.cursor_value, want.cursor_valid);
          $display("  got  st=%0d cur=%0d len=%0d word=%0d v=%0b", got.status,
                   got.cursor, got.length, got.cursor_value, got.cursor_valid);
        end
      end
    endfunction

    function int pending();
      return expected_views.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  cal_in_t            in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cal_out_t           out_data;
  logic               cfg_we = 1'b0;
  logic [FIELD_W-1:0] cfg_wdata = '0;

  list_scoreboard sb = new();
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             hold_left = 0;
  int             cycle_count = 0;

  cursor_array_list_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: check on handshake, then pick next cycle's ready.
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_result(out_data);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic [2:0] mode, logic signed [WORD_W-1:0] value);
    cal_in_t req;
    req.mode = mode;
    req.value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  // Drop valid and hold until every pending result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [FIELD_W-1:0] lim);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.limit = lim;
  endtask

  function automatic logic [2:0] pick_mode(op_mix_t mix);
    int w_ins;
    int w_app;
    int w_rem;
    int w_clr;
    int r;
    case (mix)
      MIX_GROW:   begin w_ins = 30; w_app = 30; w_rem = 11; w_clr = 1; end
      MIX_SHRINK: begin w_ins = 12; w_app = 8;  w_rem = 50; w_clr = 2; end
      default:    begin w_ins = 20; w_app = 14; w_rem = 20; w_clr = 2; end
    endcase
    r = $urandom_range(99);
    if (r < w_ins) return MODE_INSERT;
    r -= w_ins;
    if (r < w_app) return MODE_APPEND;
    r -= w_app;
    if (r < w_rem) return MODE_REMOVE;
    r -= w_rem;
    if (r < w_clr) return MODE_CLEAR;
    case ($urandom_range(3))
      0:       return MODE_START;
      1:       return MODE_END;
      2:       return MODE_PREV;
      default: return MODE_NEXT;
    endcase
  endfunction

  task automatic random_run(int n, op_mix_t mix);
    repeat (n) send_request(pick_mode(mix), $urandom);
  endtask

  initial begin
    send_idle_pct = 23;
    recv_idle_pct = 81;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list edges, word extremes, full list, remove at end.
    write_limit(7'd4);
    send_request(MODE_PREV, $urandom);
    send_request(MODE_NEXT, $urandom);
    send_request(MODE_REMOVE, $urandom);
    send_request(MODE_INSERT, 32'sh8000_0000);
    send_request(MODE_INSERT, 32'sh7fff_ffff);
    send_request(MODE_NEXT, $urandom);
    send_request(MODE_APPEND, -32'sd1);
    send_request(MODE_APPEND, 32'sd0);
    send_request(MODE_INSERT, 32'sd5);
    send_request(MODE_APPEND, 32'sd6);
    send_request(MODE_NEXT, $urandom);
    send_request(MODE_START, $urandom);
    send_request(MODE_NEXT, $urandom);
    send_request(MODE_REMOVE, $urandom);
    send_request(MODE_END, $urandom);
    send_request(MODE_REMOVE, $urandom);
    send_request(MODE_PREV, $urandom);
    send_request(MODE_REMOVE, $urandom);
    drain_results();

    // Limit below current length: inserts fail until enough entries go.
    write_limit(7'd1);
    send_request(MODE_START, $urandom);
    send_request(MODE_INSERT, 32'sh5555_5555);
    send_request(MODE_APPEND, 32'shaaaa_aaaa);
    send_request(MODE_REMOVE, $urandom);
    send_request(MODE_INSERT, 32'sh0f0f_0f0f);
    send_request(MODE_CLEAR, $urandom);
    send_request(MODE_INSERT, 32'sd1);
    drain_results();

    write_limit(7'd64);
    random_run(250, MIX_GROW);
    drain_results();

    send_idle_pct = 81;
    recv_idle_pct = 23;
    write_limit(7'd0);
    random_run(20, MIX_EVEN);
    drain_results();
    write_limit(FIELD_W'($urandom_range(12, 1)));
    random_run(230, MIX_EVEN);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(7'd64);
    random_run(150, MIX_GROW);
    // Stall the result side for a long stretch while requests keep coming.
    hold_left = 150;
    random_run(100, MIX_EVEN);
    drain_results();
    random_run(100, MIX_SHRINK);
    drain_results();
    repeat (8) @(posedge clk);

    $display("Covered %0d requests and %0d results; deepest list %0d entries,",
             sb.noted, sb.checked, sb.deepest);
    $display("%0d rejected for a full list, %0d removes with no entry, %0d mismatches",
             sb.full_hits, sb.empty_removes, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
